@@ design/bvalu_pkg.sv @@
// Shared types, constants and helpers for the bitvector operator unit.
`timescale 1ns / 1ps
`default_nettype none
package bvalu_pkg;

  localparam int DATA_WIDTH = 64;
  localparam int WIDTH_BITS = 7;
  localparam int DIV_STEPS  = DATA_WIDTH;
  // prep, two multiplier stages, one stage per quotient bit, output register
  localparam int LATENCY    = 1 + 2 + DIV_STEPS + 1;

  typedef enum logic [4:0] {
    K_ADD, K_MUL, K_AND, K_OR, K_XOR, K_NOT, K_SHL, K_LSHR, K_ASHR,
    K_UDIV, K_SDIV, K_UREM, K_SREM, K_ROL, K_ROR, K_EXTRACT, K_CONCAT,
    K_ZEXT, K_SEXT, K_ITE, K_EQ, K_ULT, K_ULE, K_SLT, K_SLE
  } kind_t;

  typedef struct packed {
    logic                  valid;
    kind_t                 kind;
    logic [WIDTH_BITS-1:0] w;
    logic                  neg_q;
    logic                  neg_r;
    logic [DATA_WIDTH-1:0] val;
  } side_t;

  function automatic logic [DATA_WIDTH-1:0] width_mask(input logic [WIDTH_BITS-1:0] w);
    return ~({DATA_WIDTH{1'b1}} << w);
  endfunction

  function automatic logic [WIDTH_BITS-1:0] clamp_width(input logic [WIDTH_BITS-1:0] x);
    if (x == '0) return WIDTH_BITS'(1);
    if (x > WIDTH_BITS'(DATA_WIDTH)) return WIDTH_BITS'(DATA_WIDTH);
    return x;
  endfunction

endpackage
`default_nettype wire

@@ design/bvalu_prep.sv @@
// Input stage: width clamping, operand masking, simple operators, divider setup.
`timescale 1ns / 1ps
`default_nettype none
module bvalu_prep (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   take,
  input  wire logic [4:0]                             kind,
  input  wire logic [6:0]                             result_width,
  input  wire logic [6:0]                             source_width,
  input  wire logic [63:0]                            operand_a,
  input  wire logic [63:0]                            operand_b,
  input  wire logic [63:0]                            operand_c,
  input  wire logic [5:0]                             bit_offset,
  output bvalu_pkg::side_t                            side,
  output logic [bvalu_pkg::DATA_WIDTH-1:0]            ma,
  output logic [bvalu_pkg::DATA_WIDTH-1:0]            mb,
  output logic [bvalu_pkg::DATA_WIDTH-1:0]            dividend,
  output logic [bvalu_pkg::DATA_WIDTH-1:0]            divisor
);
  import bvalu_pkg::*;

  logic [WIDTH_BITS-1:0] w, s;
  logic [DATA_WIDTH-1:0] mw, ms, a, b, c, as, bs, ext_a, sxa, sxb, abs_a, abs_b;
  logic                  sa, sb, ssa, ssb, b_big;
  kind_t                 k;
  side_t                 side_next;
  logic [DATA_WIDTH-1:0] dividend_next, divisor_next;

  always_comb begin
    k     = kind_t'(kind);
    w     = clamp_width(result_width);
    s     = clamp_width(source_width);
    mw    = width_mask(w);
    ms    = width_mask(s);
    a     = operand_a & mw;
    b     = operand_b & mw;
    c     = operand_c & mw;
    as    = operand_a & ms;
    bs    = operand_b & ms;
    sa    = a[6'(w - 7'd1)];
    sb    = b[6'(w - 7'd1)];
    ssa   = as[6'(s - 7'd1)];
    ssb   = bs[6'(s - 7'd1)];
    b_big = b >= DATA_WIDTH'(w);
    ext_a = a | (sa ? ~mw : '0);
    sxa   = as | (ssa ? ~ms : '0);
    sxb   = bs | (ssb ? ~ms : '0);
    abs_a = sa ? ((~a + 1'b1) & mw) : a;
    abs_b = sb ? ((~b + 1'b1) & mw) : b;

    side_next       = '0;
    side_next.valid = take;
    side_next.kind  = k;
    side_next.w     = w;
    dividend_next   = a;
    divisor_next    = b;
    unique case (k)
      K_ADD:     side_next.val = a + b;
      K_MUL:     side_next.val = '0;
      K_AND:     side_next.val = a & b;
      K_OR:      side_next.val = a | b;
      K_XOR:     side_next.val = a ^ b;
      K_NOT:     side_next.val = ~a;
      K_SHL:     side_next.val = b_big ? '0 : (a << b[5:0]);
      K_LSHR:    side_next.val = b_big ? '0 : (a >> b[5:0]);
      K_ASHR:    side_next.val = b_big ? (sa ? mw : '0)
                                       : DATA_WIDTH'($signed(ext_a) >>> b[5:0]);
      K_UDIV, K_UREM: side_next.val = '0;
      K_SDIV, K_SREM: begin
        dividend_next   = abs_a;
        divisor_next    = abs_b;
        side_next.neg_q = sa ^ sb;
        side_next.neg_r = sa;
      end
      K_ROL, K_ROR: begin
        // remainder of amount by width comes out of the divider
        side_next.val = a;
        dividend_next = b;
        divisor_next  = DATA_WIDTH'(w);
      end
      K_EXTRACT: side_next.val = as >> bit_offset;
      K_CONCAT:  side_next.val = (operand_a << s) | bs;
      K_ZEXT:    side_next.val = as;
      K_SEXT:    side_next.val = sxa;
      K_ITE:     side_next.val = (operand_a != '0) ? b : c;
      K_EQ:      side_next.val = DATA_WIDTH'(as == bs);
      K_ULT:     side_next.val = DATA_WIDTH'(as < bs);
      K_ULE:     side_next.val = DATA_WIDTH'(as <= bs);
      K_SLT:     side_next.val = DATA_WIDTH'($signed(sxa) < $signed(sxb));
      K_SLE:     side_next.val = DATA_WIDTH'($signed(sxa) <= $signed(sxb));
      default:   side_next.val = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side.valid <= 1'b0;
    end else begin
      side     <= side_next;
      ma       <= a;
      mb       <= b;
      dividend <= dividend_next;
      divisor  <= divisor_next;
    end
  end

endmodule
`default_nettype wire

@@ design/bvalu_mul.sv @@
// Two-stage low-half multiplier from 32x32 partial products; passes divider operands.
`timescale 1ns / 1ps
`default_nettype none
module bvalu_mul (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  bvalu_pkg::side_t                            side_in,
  input  wire logic [bvalu_pkg::DATA_WIDTH-1:0]       ma,
  input  wire logic [bvalu_pkg::DATA_WIDTH-1:0]       mb,
  input  wire logic [bvalu_pkg::DATA_WIDTH-1:0]       dividend_in,
  input  wire logic [bvalu_pkg::DATA_WIDTH-1:0]       divisor_in,
  output bvalu_pkg::side_t                            side_out,
  output logic [bvalu_pkg::DATA_WIDTH-1:0]            dividend_out,
  output logic [bvalu_pkg::DATA_WIDTH-1:0]            divisor_out
);
  import bvalu_pkg::*;

  localparam int HW = DATA_WIDTH / 2;

  side_t                 side_m, side_next;
  logic [DATA_WIDTH-1:0] p0, dvd_m, dvs_m, prod;
  logic [HW-1:0]         p1, p2;

  always_ff @(posedge clk) begin
    if (rst) begin
      side_m.valid <= 1'b0;
    end else begin
      side_m <= side_in;
      p0     <= DATA_WIDTH'(ma[HW-1:0] * mb[HW-1:0]);
      p1     <= HW'(ma[HW-1:0] * mb[DATA_WIDTH-1:HW]);
      p2     <= HW'(ma[DATA_WIDTH-1:HW] * mb[HW-1:0]);
      dvd_m  <= dividend_in;
      dvs_m  <= divisor_in;
    end
  end

  assign prod = p0 + {p1 + p2, {HW{1'b0}}};

  always_comb begin
    side_next = side_m;
    if (side_m.kind == K_MUL) side_next.val = prod;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_out.valid <= 1'b0;
    end else begin
      side_out     <= side_next;
      dividend_out <= dvd_m;
      divisor_out  <= dvs_m;
    end
  end

endmodule
`default_nettype wire

@@ design/bvalu_div.sv @@
// Restoring unsigned divider, one quotient bit per pipeline stage.
`timescale 1ns / 1ps
`default_nettype none
module bvalu_div (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  bvalu_pkg::side_t                            side_in,
  input  wire logic [bvalu_pkg::DATA_WIDTH-1:0]       dividend,
  input  wire logic [bvalu_pkg::DATA_WIDTH-1:0]       divisor,
  output bvalu_pkg::side_t                            side_out,
  output logic [bvalu_pkg::DATA_WIDTH-1:0]            quo,
  output logic [bvalu_pkg::DATA_WIDTH-1:0]            rem
);
  import bvalu_pkg::*;

  side_t                 sd  [0:DIV_STEPS];
  logic [DATA_WIDTH-1:0] rm  [0:DIV_STEPS];
  logic [DATA_WIDTH-1:0] qt  [0:DIV_STEPS];
  logic [DATA_WIDTH-1:0] dn  [0:DIV_STEPS];

  assign sd[0] = side_in;
  assign rm[0] = '0;
  assign qt[0] = dividend;
  assign dn[0] = divisor;

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
    logic [DATA_WIDTH:0] t;
    logic                fit;
    // zero divisor always fits: all-ones quotient, dividend as remainder
    assign t   = {rm[i], qt[i][DATA_WIDTH-1]};
    assign fit = t >= {1'b0, dn[i]};

    always_ff @(posedge clk) begin
      if (rst) begin
        sd[i+1].valid <= 1'b0;
      end else begin
        sd[i+1] <= sd[i];
        rm[i+1] <= fit ? DATA_WIDTH'(t - {1'b0, dn[i]}) : t[DATA_WIDTH-1:0];
        qt[i+1] <= {qt[i][DATA_WIDTH-2:0], fit};
        dn[i+1] <= dn[i];
      end
    end
  end

  assign side_out = sd[DIV_STEPS];
  assign quo      = qt[DIV_STEPS];
  assign rem      = rm[DIV_STEPS];

endmodule
`default_nettype wire

@@ design/bitvector_operator_alu.sv @@
// Top level of the bitvector operator unit: pipeline and result stage.
// Takes one item per clock; each result passes through one input stage, two
// multiplier stages, one divider stage per bit of the 64-bit restoring divider
// and the output register. busy stays low; done marks result for one cycle and
// the receiver cannot stall it.
`timescale 1ns / 1ps
`default_nettype none
module bitvector_operator_alu (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [4:0]  kind,
  input  wire logic [6:0]  result_width,
  input  wire logic [6:0]  source_width,
  input  wire logic [63:0] operand_a,
  input  wire logic [63:0] operand_b,
  input  wire logic [63:0] operand_c,
  input  wire logic [5:0]  bit_offset,
  output logic             done,
  output logic [63:0]      result
);
  import bvalu_pkg::*;

  side_t                 side_p, side_m, side_d;
  logic [DATA_WIDTH-1:0] ma, mb, dvd_p, dvs_p, dvd_m, dvs_m, quo, rem;
  logic [WIDTH_BITS-1:0] amt, k;
  logic [DATA_WIDTH-1:0] rot, res;

  assign busy = 1'b0;

  bvalu_prep u_prep (
    .clk, .rst, .take(start & ~busy), .kind, .result_width, .source_width,
    .operand_a, .operand_b, .operand_c, .bit_offset,
    .side(side_p), .ma, .mb, .dividend(dvd_p), .divisor(dvs_p)
  );

  bvalu_mul u_mul (
    .clk, .rst, .side_in(side_p), .ma, .mb, .dividend_in(dvd_p), .divisor_in(dvs_p),
    .side_out(side_m), .dividend_out(dvd_m), .divisor_out(dvs_m)
  );

  bvalu_div u_div (
    .clk, .rst, .side_in(side_m), .dividend(dvd_m), .divisor(dvs_m),
    .side_out(side_d), .quo, .rem
  );

  always_comb begin
    k   = rem[WIDTH_BITS-1:0];
    amt = (side_d.kind == K_ROR && k != '0) ? side_d.w - k : k;
    rot = (side_d.val << amt) | (side_d.val >> (side_d.w - amt));
    unique case (side_d.kind)
      K_UDIV:       res = quo;
      K_SDIV:       res = side_d.neg_q ? ~quo + 1'b1 : quo;
      K_UREM:       res = rem;
      K_SREM:       res = side_d.neg_r ? ~rem + 1'b1 : rem;
      K_ROL, K_ROR: res = rot;
      default:      res = side_d.val;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done   <= side_d.valid;
      result <= res & width_mask(side_d.w);
    end
  end

endmodule
`default_nettype wire

@@ design/bvalu_chk.sv @@
// Port-level checker for the bitvector operator unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module bvalu_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [4:0]  kind,
  input wire logic        done,
  input wire logic [63:0] result
);
  import bvalu_pkg::*;

  a_latency_fwd: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LATENCY done)
    else $error("item taken without result after fixed latency");

  a_latency_back: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without a matching item");

  a_compare_bit: assert property (@(posedge clk) disable iff (rst)
    done && ($past(kind, LATENCY) == 5'(K_EQ) || $past(kind, LATENCY) == 5'(K_ULT) ||
             $past(kind, LATENCY) == 5'(K_SLT)) |-> result[63:1] == '0)
    else $error("compare result wider than one bit");

  a_unused_kind: assert property (@(posedge clk) disable iff (rst)
    done && $past(kind, LATENCY) > 5'(K_SLE) |-> result == '0)
    else $error("unused kind gave nonzero result");

endmodule

bind bitvector_operator_alu bvalu_chk u_bvalu_chk (
  .clk, .rst, .start, .busy, .kind, .done, .result
);
`default_nettype wire
